[hw/rtl/sttr_pkg.sv]
// shared types, codes and constants of the trapezoidal stepper ramp
package sttr_pkg;

    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int SCALED_W   = 32;
    localparam int TICKS_W    = 32;
    localparam int INTERVAL_W = 23;
    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int PHASE_W    = 2;
    localparam int PADDR_W    = 4;

    localparam int INTERVAL_SCALE_DEF = 1000;
    localparam int MIN_INTERVAL_DEF   = 10;

    // divider: dividend holds 2c or c, divisor holds 4n+1, 4n-1 or the scale
    localparam int DIVIDEND_W = 34;
    localparam int DIVISOR_W  = 18;
    localparam int REM_W      = DIVISOR_W + 1;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS  = DIVIDEND_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [FUNC_W-1:0] FUNC_TIME  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WAIT  = 2'd2;

    localparam logic [1:0] CFG_TOTAL    = 2'd0;
    localparam logic [1:0] CFG_ACCEL    = 2'd1;
    localparam logic [1:0] CFG_CRUISE   = 2'd2;
    localparam logic [1:0] CFG_INTERVAL = 2'd3;

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_CONST = 2'd2,
        PH_DECEL = 2'd3
    } phase_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] total_steps;
        logic [COUNT_W-1:0]        accel_end_step;
        logic [COUNT_W-1:0]        cruise_end_step;
        logic [SCALED_W-1:0]       initial_interval_scaled;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic step_go;
        logic c_update;
        logic tick_go;
        logic ticks_update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_step;
        logic need_tick;
        logic div_done;
        logic out_full;
    } sts_t;

endpackage

[hw/rtl/sttr_regs.sv]
// configuration register file on the apb port
module sttr_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sttr_pkg::PADDR_W-1:0]  paddr,
    input  logic [sttr_pkg::DATA_W-1:0]   pwdata,
    output logic [sttr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output sttr_pkg::cfg_t                cfg
);
    import sttr_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                CFG_TOTAL:    cfg_next.total_steps = pwdata[COUNT_W-1:0];
                CFG_ACCEL:    cfg_next.accel_end_step = pwdata[COUNT_W-1:0];
                CFG_CRUISE:   cfg_next.cruise_end_step = pwdata[COUNT_W-1:0];
                CFG_INTERVAL: cfg_next.initial_interval_scaled = pwdata[SCALED_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            CFG_TOTAL:    prdata = DATA_W'(cfg_reg.total_steps);
            CFG_ACCEL:    prdata = DATA_W'(cfg_reg.accel_end_step);
            CFG_CRUISE:   prdata = DATA_W'(cfg_reg.cruise_end_step);
            CFG_INTERVAL: prdata = DATA_W'(cfg_reg.initial_interval_scaled);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/sttr_div.sv]
// iterative restoring divider, two quotient bits per cycle
module sttr_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sttr_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [sttr_pkg::DIVISOR_W-1:0]  divisor,
    output logic [sttr_pkg::DIVIDEND_W-1:0] quotient,
    output logic                            done
);
    import sttr_pkg::*;

    logic [DIVIDEND_W-1:0] work_reg;
    logic [DIVIDEND_W-1:0] work_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_CNT_W-1:0]  cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;

    assign quotient = work_reg;
    assign done     = done_reg;

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            rem_next  = {rem_next[REM_W-2:0], work_next[DIVIDEND_W-1]};
            work_next = {work_next[DIVIDEND_W-2:0], 1'b0};
            if (rem_next >= {1'b0, den_reg})
            begin
                rem_next     = rem_next - {1'b0, den_reg};
                work_next[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

[hw/rtl/sttr_dp.sv]
// datapath: move state, ramp recurrence, interval and result register
module sttr_dp #(
    parameter int INTERVAL_SCALE = sttr_pkg::INTERVAL_SCALE_DEF,
    parameter int MIN_INTERVAL   = sttr_pkg::MIN_INTERVAL_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sttr_pkg::cfg_t              cfg,
    input  logic [sttr_pkg::FUNC_W-1:0] func,
    input  logic [sttr_pkg::TIME_W-1:0] time_now,
    input  sttr_pkg::cmd_t              cmd,
    output sttr_pkg::sts_t              sts,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sttr_pkg::DATA_W-1:0] m_tdata
);
    import sttr_pkg::*;

    phase_t               phase_reg, phase_next;
    logic                 running_reg, running_next;
    logic                 done_reg, done_next;
    logic                 dir_reg, dir_next;
    logic                 pulse_reg, pulse_next;
    logic                 sub_reg, sub_next;
    logic [COUNT_W-1:0]   target_reg, target_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   ramp_reg, ramp_next;
    logic [SCALED_W-1:0]  c_reg, c_next;
    logic [TICKS_W-1:0]   ticks_reg, ticks_next;
    logic [TIME_W-1:0]    last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_data_reg;

    logic [TIME_W-1:0]     elapsed;
    logic                  fire;
    logic [DIVISOR_W-1:0]  step_den;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVIDEND_W-1:0] div_q;
    logic                  div_done;
    logic [SCALED_W:0]     c_sum;
    logic [TICKS_W-1:0]    q_ticks;
    logic [INTERVAL_W-1:0] interval_sat;

    assign elapsed = time_now - last_reg;
    assign fire    = (func == FUNC_TIME) && running_reg && (elapsed > ticks_reg);
    assign step_den = (phase_reg == PH_ACCEL) ? ({ramp_reg, 2'b00} + DIVISOR_W'(1))
                                              : ({ramp_reg, 2'b00} - DIVISOR_W'(1));

    assign sts.need_step = fire && ((phase_reg == PH_ACCEL) || (phase_reg == PH_DECEL));
    assign sts.need_tick = (func == FUNC_START) && (cfg.total_steps != '0);
    assign sts.div_done  = div_done;
    assign sts.out_full  = out_valid_reg && !m_tready;

    assign div_start    = cmd.step_go || cmd.tick_go;
    assign div_dividend = cmd.step_go ? {1'b0, c_reg, 1'b0} : {2'b00, c_reg};
    assign div_divisor  = cmd.step_go ? step_den : DIVISOR_W'(INTERVAL_SCALE);

    sttr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    assign c_sum   = {1'b0, c_reg} + {1'b0, div_q[SCALED_W-1:0]};
    assign q_ticks = div_q[TICKS_W-1:0];
    assign interval_sat = (|ticks_reg[TICKS_W-1:INTERVAL_W]) ? '1 : ticks_reg[INTERVAL_W-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        running_next = running_reg;
        done_next    = done_reg;
        dir_next     = dir_reg;
        pulse_next   = pulse_reg;
        sub_next     = sub_reg;
        target_next  = target_reg;
        count_next   = count_reg;
        ramp_next    = ramp_reg;
        c_next       = c_reg;
        ticks_next   = ticks_reg;
        last_next    = last_reg;

        if (cmd.take)
        begin
            pulse_next = 1'b0;
            case (func)
                FUNC_TIME:
                begin
                    if (!running_reg)
                    begin
                        done_next = 1'b1;
                    end
                    else if (fire)
                    begin
                        pulse_next = 1'b1;
                        last_next  = time_now;
                        case (phase_reg)
                            PH_ACCEL:
                            begin
                                sub_next = 1'b1;
                                if (count_reg >= cfg.accel_end_step)
                                begin
                                    phase_next = PH_CONST;
                                end
                                if (ramp_reg != '1)
                                begin
                                    ramp_next = ramp_reg + 1'b1;
                                end
                            end
                            PH_CONST:
                            begin
                                if (count_reg >= cfg.cruise_end_step)
                                begin
                                    phase_next = PH_DECEL;
                                end
                            end
                            PH_DECEL:
                            begin
                                sub_next = 1'b0;
                                if (count_reg >= target_reg)
                                begin
                                    running_next = 1'b0;
                                    done_next    = 1'b1;
                                    phase_next   = PH_WAIT;
                                end
                                if (ramp_reg > COUNT_W'(1))
                                begin
                                    ramp_next = ramp_reg - 1'b1;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                        if (count_reg != '1)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                FUNC_START:
                begin
                    if (cfg.total_steps == '0)
                    begin
                        running_next = 1'b0;
                        done_next    = 1'b1;
                        phase_next   = PH_WAIT;
                    end
                    else
                    begin
                        dir_next     = !cfg.total_steps[COUNT_W-1];
                        target_next  = cfg.total_steps[COUNT_W-1] ? (~cfg.total_steps + 1'b1)
                                                                  : cfg.total_steps;
                        running_next = 1'b1;
                        done_next    = 1'b0;
                        phase_next   = PH_ACCEL;
                        count_next   = '0;
                        ramp_next    = COUNT_W'(1);
                        c_next       = cfg.initial_interval_scaled;
                        last_next    = time_now;
                    end
                end
                FUNC_WAIT:
                begin
                    running_next = 1'b0;
                    done_next    = 1'b1;
                    phase_next   = PH_WAIT;
                end
                default:
                begin
                    pulse_next = 1'b0;
                end
            endcase
        end

        if (cmd.c_update)
        begin
            if (sub_reg)
            begin
                c_next = c_reg - div_q[SCALED_W-1:0];
            end
            else
            begin
                c_next = c_sum[SCALED_W] ? '1 : c_sum[SCALED_W-1:0];
            end
        end

        if (cmd.ticks_update)
        begin
            ticks_next = (q_ticks < TICKS_W'(MIN_INTERVAL)) ? TICKS_W'(MIN_INTERVAL) : q_ticks;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            running_reg   <= 1'b0;
            done_reg      <= 1'b0;
            dir_reg       <= 1'b0;
            pulse_reg     <= 1'b0;
            sub_reg       <= 1'b0;
            target_reg    <= '0;
            count_reg     <= '0;
            ramp_reg      <= COUNT_W'(1);
            c_reg         <= '0;
            ticks_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            running_reg   <= running_next;
            done_reg      <= done_next;
            dir_reg       <= dir_next;
            pulse_reg     <= pulse_next;
            sub_reg       <= sub_next;
            target_reg    <= target_next;
            count_reg     <= count_next;
            ramp_reg      <= ramp_next;
            c_reg         <= c_next;
            ticks_reg     <= ticks_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word: pulse, direction, done, phase, interval, zero pad
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= DATA_W'({interval_sat, phase_reg, done_reg, dir_reg, pulse_reg});
        end
    end

endmodule

[hw/rtl/sttr_ctrl.sv]
// controller: sequences request intake, divisions and result hand-off
module sttr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sttr_pkg::sts_t sts,
    output sttr_pkg::cmd_t cmd
);
    import sttr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_STEP_DIV = 5'b00010,
        ST_TICK_GO  = 5'b00100,
        ST_TICK_DIV = 5'b01000,
        ST_EMIT     = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take = 1'b1;
                    if (sts.need_step)
                    begin
                        cmd.step_go = 1'b1;
                        state_next  = ST_STEP_DIV;
                    end
                    else if (sts.need_tick)
                    begin
                        state_next = ST_TICK_GO;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_STEP_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.c_update = 1'b1;
                    state_next   = ST_TICK_GO;
                end
            end
            ST_TICK_GO:
            begin
                cmd.tick_go = 1'b1;
                state_next  = ST_TICK_DIV;
            end
            ST_TICK_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.ticks_update = 1'b1;
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/stepper_trapezoid_ramp_top.sv]
// top level of the trapezoidal ramp stepper pulse generator
//
// requests enter on the s_ stream: s_tuser carries the function code
// (time update, start move, return to wait), s_tdata the timebase value.
// every request yields exactly one result on the m_ stream, in order.
// the apb port holds move length, ramp end points and first interval;
// write it only while no request is in work.
// a time update that issues a step while accelerating or decelerating
// runs two divisions on one shared radix-4 divider, the step division and
// then the interval division; a start of a nonzero move runs the interval
// division only, and any other request runs none. one request is in work
// at a time. the result register lets the next request enter while a
// result still waits on m_tready; a stalled receiver holds back the
// following result and, until that result is loaded, the intake of
// further requests. reset clears the move state to wait with all
// configuration registers at zero; no clearing pass is needed.
module stepper_trapezoid_ramp_top #(
    parameter int INTERVAL_SCALE = sttr_pkg::INTERVAL_SCALE_DEF,
    parameter int MIN_INTERVAL   = sttr_pkg::MIN_INTERVAL_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sttr_pkg::TIME_W-1:0]  s_tdata,   // time_now
    input  logic [sttr_pkg::FUNC_W-1:0]  s_tuser,   // func
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // step_pulse, direction, done_res, phase[1:0], interval[22:0], zero pad
    output logic [sttr_pkg::DATA_W-1:0]  m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sttr_pkg::PADDR_W-1:0] paddr,
    input  logic [sttr_pkg::DATA_W-1:0]  pwdata,
    output logic [sttr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import sttr_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    sttr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sttr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sttr_dp #(
        .INTERVAL_SCALE (INTERVAL_SCALE),
        .MIN_INTERVAL   (MIN_INTERVAL)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .func     (s_tuser),
        .time_now (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hw/rtl/sttr_checker.sv]
// port-level checks of the stepper ramp top, bound to the top level
module sttr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [sttr_pkg::DATA_W-1:0]  m_tdata
);
    import sttr_pkg::*;

    logic       s_acc;
    logic       m_acc;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // requests taken whose results are not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (s_acc && !m_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (m_acc && !s_acc)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_tready)
        else $error("second request taken while one is in work");

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result without a request");

    a_take_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |-> pending_reg == 2'd0 || pending_reg == 2'd1)
        else $error("too many requests in flight");

    a_pulse_interval: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[27:5] != 23'd0)
        else $error("step issued with zero interval");

endmodule

bind stepper_trapezoid_ramp_top sttr_checker u_sttr_checker (.*);
